@@ rtl/core/cgi_pkg.sv @@
// shared types and constants for the color gradient interpolator
`timescale 1ns / 1ps

package cgi_pkg;

   localparam int MAX_STOPS_DEFAULT = 6;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int POS_BITS        = 17;
   localparam int RGB_BITS        = 24;
   localparam int CHAN_BITS       = 8;
   localparam int CHANNELS        = 3;
   localparam int STOP_BITS       = POS_BITS + RGB_BITS;
   localparam int STOP_POS_LSB    = RGB_BITS;
   localparam int STOP_COUNT_BITS = 3;
   localparam int POSITION_BITS   = 32;

   localparam logic [POS_BITS-1:0]        POS_ONE          = 17'h10000;
   localparam logic [STOP_COUNT_BITS-1:0] STOP_COUNT_RESET = 3'd2;
   localparam logic [STOP_COUNT_BITS-1:0] STOP_COUNT_MIN   = 3'd2;
   localparam logic [STOP_BITS-1:0]       STOP_ONE_RESET   = {POS_ONE, 24'hFFFFFF};

   // register indexes
   localparam int CSR_STOP_COUNT = 0;
   localparam int CSR_STOP_BASE  = 1;

   typedef enum logic [1:0] {
      FRAC_DIVIDE,
      FRAC_ZERO,
      FRAC_ONE
   } cgi_frac_mode_type;

   typedef struct packed {
      logic              valid;
      cgi_frac_mode_type mode;
   } cgi_div_ctl_type;

   typedef struct packed {
      logic [RGB_BITS-1:0] rgb_lo;
      logic [RGB_BITS-1:0] rgb_hi;
   } cgi_colors_type;

endpackage

@@ rtl/core/cgi_frac_div.sv @@
// pipelined restoring divider for the segment fraction, one quotient bit per stage
`timescale 1ns / 1ps

module cgi_frac_div #(
   parameter int FRAC_BITS = cgi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  cgi_pkg::cgi_div_ctl_type         in_ctl,
   input  logic [cgi_pkg::POS_BITS-1:0]     in_rem,
   input  logic [cgi_pkg::POS_BITS-1:0]     in_den,
   input  cgi_pkg::cgi_colors_type          in_colors,
   output logic                             out_valid,
   output logic [FRAC_BITS:0]               out_frac,
   output cgi_pkg::cgi_colors_type          out_colors
);
   import cgi_pkg::*;

   cgi_div_ctl_type       ctl_ff    [FRAC_BITS];
   logic [POS_BITS-1:0]   rem_ff    [FRAC_BITS];
   logic [POS_BITS-1:0]   den_ff    [FRAC_BITS];
   logic [FRAC_BITS-1:0]  q_ff      [FRAC_BITS];
   cgi_colors_type        colors_ff [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      cgi_div_ctl_type      ctl_src;
      cgi_colors_type       colors_src;
      logic [POS_BITS-1:0]  rem_src;
      logic [POS_BITS-1:0]  den_src;
      logic [FRAC_BITS-1:0] q_src;
      logic [POS_BITS:0]    rem_dbl;
      logic [POS_BITS:0]    rem_sub;
      logic                 take;
      logic [POS_BITS-1:0]  rem_in;
      logic [FRAC_BITS-1:0] q_in;

      if (k == 0) begin : g_first
         assign ctl_src    = in_ctl;
         assign colors_src = in_colors;
         assign rem_src    = in_rem;
         assign den_src    = in_den;
         assign q_src      = '0;
      end else begin : g_next
         assign ctl_src    = ctl_ff[k-1];
         assign colors_src = colors_ff[k-1];
         assign rem_src    = rem_ff[k-1];
         assign den_src    = den_ff[k-1];
         assign q_src      = q_ff[k-1];
      end

      assign rem_dbl = {rem_src, 1'b0};
      assign take    = rem_dbl >= {1'b0, den_src};
      assign rem_sub = rem_dbl - {1'b0, den_src};
      assign rem_in  = take ? rem_sub[POS_BITS-1:0] : rem_dbl[POS_BITS-1:0];
      assign q_in    = {q_src[FRAC_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
            ctl_ff[k].mode  <= FRAC_ZERO;
         end else if (advance) begin
            ctl_ff[k] <= ctl_src;
         end
         if (advance) begin
            rem_ff[k]    <= rem_in;
            den_ff[k]    <= den_src;
            q_ff[k]      <= q_in;
            colors_ff[k] <= colors_src;
         end
      end
   end

   assign out_valid  = ctl_ff[FRAC_BITS-1].valid;
   assign out_colors = colors_ff[FRAC_BITS-1];

   always_comb begin
      case (ctl_ff[FRAC_BITS-1].mode)
         FRAC_DIVIDE: out_frac = {1'b0, q_ff[FRAC_BITS-1]};
         FRAC_ONE:    out_frac = {1'b1, {FRAC_BITS{1'b0}}};
         default:     out_frac = '0;
      endcase
   end

endmodule

@@ rtl/core/color_gradient_interpolator.sv @@
// top level of the piecewise linear color gradient interpolator
`timescale 1ns / 1ps

// Takes one signed Q15.16 position per item and returns one 24-bit RGB color
// per item. The block accepts an item every clock cycle while req_stall is
// low. The fraction divider resolves one quotient bit per pipeline stage. The
// other stages are the magnitude clamp, the parallel stop search, the segment
// setup, the channel multiply and the rounding output register. A result held
// by rsp_stall freezes the whole pipeline and is seen on req_stall at once.
// The user must write stops through the csr port only while no item is in
// flight; the block itself does not enforce this. Index 0 is the stop count,
// index 1 + i is stop i (position in bits 40..24, Q1.16, color in bits
// 23..0).

module color_gradient_interpolator #(
   parameter int MAX_STOPS = cgi_pkg::MAX_STOPS_DEFAULT,
   parameter int FRAC_BITS = cgi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cgi_pkg::POSITION_BITS-1:0] req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cgi_pkg::RGB_BITS-1:0]           rsp_rgb,
   input  logic                                   csr_write,
   input  logic [$clog2(MAX_STOPS+1)-1:0]         csr_index,
   input  logic [cgi_pkg::STOP_BITS-1:0]          csr_data
);
   import cgi_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_STOPS + 1);
   localparam int SEG_BITS  = $clog2(MAX_STOPS);
   localparam int PROD_BITS = FRAC_BITS + CHAN_BITS + 1;
   localparam logic [STOP_COUNT_BITS-1:0] MaxStopsCode = STOP_COUNT_BITS'(MAX_STOPS);
   localparam logic [PROD_BITS-1:0]       Half         = PROD_BITS'(1) << (FRAC_BITS - 1);

   logic advance;

   // configuration
   logic [STOP_COUNT_BITS-1:0] stop_count_ff;
   logic [STOP_BITS-1:0]       stops_ff [MAX_STOPS];
   logic [STOP_COUNT_BITS-1:0] count_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= STOP_COUNT_RESET;
         for (int i = 0; i < MAX_STOPS; i++) begin
            stops_ff[i] <= (i == 1) ? STOP_ONE_RESET : '0;
         end
      end else if (csr_write) begin
         if (csr_index == IDX_BITS'(CSR_STOP_COUNT)) begin
            stop_count_ff <= csr_data[STOP_COUNT_BITS-1:0];
         end
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (csr_index == IDX_BITS'(i + CSR_STOP_BASE)) begin
               stops_ff[i] <= csr_data;
            end
         end
      end
   end

   always_comb begin
      if (stop_count_ff < STOP_COUNT_MIN) begin
         count_eff = STOP_COUNT_MIN;
      end else if (stop_count_ff > MaxStopsCode) begin
         count_eff = MaxStopsCode;
      end else begin
         count_eff = stop_count_ff;
      end
   end

   // stage 1: magnitude and clamp
   logic                     s1_valid_ff;
   logic [POS_BITS-1:0]      s1_pos_ff;
   logic [POSITION_BITS-1:0] mag_in;
   logic [POS_BITS-1:0]      s1_pos_in;

   assign mag_in    = req_position[POSITION_BITS-1] ? (~req_position + 1'b1) : req_position;
   assign s1_pos_in = (mag_in > POSITION_BITS'(POS_ONE)) ? POS_ONE : mag_in[POS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_pos_ff <= s1_pos_in;
      end
   end

   // stage 2: stop search and segment select
   logic                 s2_valid_ff;
   logic [POS_BITS-1:0]  s2_pos_ff;
   logic [POS_BITS-1:0]  s2_lo_ff;
   logic [POS_BITS-1:0]  s2_hi_ff;
   cgi_colors_type       s2_colors_ff;
   logic [SEG_BITS-1:0]  seg_in;
   logic [SEG_BITS-1:0]  seg_hi;
   logic [STOP_COUNT_BITS-1:0] seg_base;

   assign seg_base = count_eff - STOP_COUNT_MIN;

   always_comb begin
      seg_in = seg_base[SEG_BITS-1:0];
      for (int i = MAX_STOPS - 1; i >= 1; i--) begin
         if ((STOP_COUNT_BITS'(i) < count_eff) &&
             (stops_ff[i][STOP_BITS-1:STOP_POS_LSB] >= s1_pos_ff)) begin
            seg_in = SEG_BITS'(i - 1);
         end
      end
   end

   assign seg_hi = seg_in + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_pos_ff           <= s1_pos_ff;
         s2_lo_ff            <= stops_ff[seg_in][STOP_BITS-1:STOP_POS_LSB];
         s2_hi_ff            <= stops_ff[seg_hi][STOP_BITS-1:STOP_POS_LSB];
         s2_colors_ff.rgb_lo <= stops_ff[seg_in][RGB_BITS-1:0];
         s2_colors_ff.rgb_hi <= stops_ff[seg_hi][RGB_BITS-1:0];
      end
   end

   // stage 3: segment setup for the divider
   cgi_div_ctl_type     s3_ctl_ff;
   cgi_div_ctl_type     s3_ctl_in;
   logic [POS_BITS-1:0] s3_rem_ff;
   logic [POS_BITS-1:0] s3_den_ff;
   cgi_colors_type      s3_colors_ff;
   logic [POS_BITS-1:0] rem_in;
   logic [POS_BITS-1:0] den_in;

   assign rem_in = s2_pos_ff - s2_lo_ff;
   assign den_in = s2_hi_ff - s2_lo_ff;

   always_comb begin
      s3_ctl_in.valid = s2_valid_ff;
      if ((s2_hi_ff <= s2_lo_ff) || (s2_pos_ff <= s2_lo_ff)) begin
         // reversed pair saturates to the upper stop once past it
         if ((s2_hi_ff < s2_lo_ff) && (s2_pos_ff >= s2_hi_ff)) begin
            s3_ctl_in.mode = FRAC_ONE;
         end else begin
            s3_ctl_in.mode = FRAC_ZERO;
         end
      end else if (rem_in >= den_in) begin
         s3_ctl_in.mode = FRAC_ONE;
      end else begin
         s3_ctl_in.mode = FRAC_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.mode  <= FRAC_ZERO;
      end else if (advance) begin
         s3_ctl_ff <= s3_ctl_in;
      end
      if (advance) begin
         s3_rem_ff    <= rem_in;
         s3_den_ff    <= den_in;
         s3_colors_ff <= s2_colors_ff;
      end
   end

   // fraction divider
   logic                 div_valid;
   logic [FRAC_BITS:0]   div_frac;
   cgi_colors_type       div_colors;

   cgi_frac_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (s3_ctl_ff),
      .in_rem     (s3_rem_ff),
      .in_den     (s3_den_ff),
      .in_colors  (s3_colors_ff),
      .out_valid  (div_valid),
      .out_frac   (div_frac),
      .out_colors (div_colors)
   );

   // stage 4: channel multiply
   logic                  s4_valid_ff;
   logic [PROD_BITS-1:0]  s4_prod_ff [CHANNELS];
   logic [CHAN_BITS-1:0]  s4_base_ff [CHANNELS];
   logic                  s4_up_ff   [CHANNELS];
   logic [PROD_BITS-1:0]  prod_in    [CHANNELS];
   logic [CHAN_BITS-1:0]  base_in    [CHANNELS];
   logic                  up_in      [CHANNELS];

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic [CHAN_BITS-1:0] ca;
         logic [CHAN_BITS-1:0] cb;
         logic [CHAN_BITS-1:0] diff;
         ca         = div_colors.rgb_lo[c*CHAN_BITS +: CHAN_BITS];
         cb         = div_colors.rgb_hi[c*CHAN_BITS +: CHAN_BITS];
         up_in[c]   = cb >= ca;
         diff       = up_in[c] ? (cb - ca) : (ca - cb);
         base_in[c] = ca;
         prod_in[c] = PROD_BITS'(diff) * PROD_BITS'(div_frac);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= div_valid;
      end
      if (advance) begin
         for (int c = 0; c < CHANNELS; c++) begin
            s4_prod_ff[c] <= prod_in[c];
            s4_base_ff[c] <= base_in[c];
            s4_up_ff[c]   <= up_in[c];
         end
      end
   end

   // output stage: round half away from zero and apply
   logic                 rsp_valid_ff;
   logic [RGB_BITS-1:0]  rsp_rgb_ff;
   logic [RGB_BITS-1:0]  rgb_in;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic [PROD_BITS-1:0] rounded;
         logic [CHAN_BITS-1:0] step;
         rounded = s4_prod_ff[c] + Half;
         step    = rounded[FRAC_BITS +: CHAN_BITS];
         rgb_in[c*CHAN_BITS +: CHAN_BITS] = s4_up_ff[c] ? (s4_base_ff[c] + step)
                                                        : (s4_base_ff[c] - step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         rsp_rgb_ff <= rgb_in;
      end
   end

   // the whole pipeline holds while a finished item waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rgb   = rsp_rgb_ff;

endmodule
